[rtl/sle_pkg.sv]
// Shared types and constants for the sorted list engine.
`default_nettype none

package sle_pkg;

    localparam int CAPACITY = 16;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_ORD   = 3'd1,
        OP_INS_END   = 3'd2,
        OP_REM_FRONT = 3'd3,
        OP_REM_VAL   = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic    capture;  // latch compare flags against the incoming value
        logic    ins;      // apply an insert (list has room)
        logic    rem;      // apply a removal
        t_opcode op;       // opcode of the beat being applied
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/sle_cell.sv]
// One list position: holds an entry, compares it and shifts with its neighbors.
`default_nettype none

module sle_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sle_pkg::t_cell_ctl i_ctl,
    input  wire logic [31:0]        i_cmp_value,
    input  wire logic [31:0]        i_new_value,
    input  wire logic [31:0]        i_left_val,
    input  wire logic               i_left_used,
    input  wire logic [31:0]        i_right_val,
    input  wire logic               i_right_used,
    input  wire logic               i_hit_before,
    input  wire logic [31:0]        i_acc,
    output logic [31:0]             o_val,
    output logic                    o_used,
    output logic                    o_hit_thru,
    output logic [31:0]             o_acc
);
    import sle_pkg::*;

    logic [31:0] r_val;
    logic [31:0] n_val;
    logic        r_used;
    logic        n_used;
    logic        r_gt;
    logic        r_eq;
    logic        w_hit;
    logic        w_at_pos;

    // Capture compare flags at accept; they are used in the apply cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_gt <= ($signed(i_cmp_value) > $signed(r_val));
            r_eq <= (i_cmp_value == r_val);
        end
    end

    always_comb begin
        case (i_ctl.op)
            OP_INS_FRONT: w_hit = 1'b1;
            OP_INS_ORD:   w_hit = !r_used || !r_gt;
            OP_INS_END:   w_hit = !r_used;
            OP_REM_FRONT: w_hit = r_used;
            OP_REM_VAL:   w_hit = r_used && r_eq;
            default:      w_hit = 1'b0;
        endcase
    end

    assign w_at_pos   = w_hit && !i_hit_before;
    assign o_hit_thru = i_hit_before || w_hit;
    assign o_acc      = i_acc | (w_at_pos ? r_val : 32'd0);
    assign o_val      = r_val;
    assign o_used     = r_used;

    always_comb begin
        n_val  = r_val;
        n_used = r_used;
        if (i_ctl.ins) begin
            if (i_hit_before) begin
                n_val  = i_left_val;
                n_used = i_left_used;
            end else if (w_at_pos) begin
                n_val  = i_new_value;
                n_used = 1'b1;
            end
        end else if (i_ctl.rem) begin
            if (i_hit_before || w_at_pos) begin
                n_val  = i_right_val;
                n_used = i_right_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_used;
        end
    end

endmodule

`default_nettype wire

[rtl/sorted_list_engine.sv]
// Top level of the sorted list engine: command port and the chain of list cells.
`default_nettype none

// Bounded list of signed 32-bit values held in a row of CAPACITY cells,
// cell 0 being the front. A command beat is taken when start is high and
// busy is low. Each beat is handled in order: in the accept cycle every cell
// compares the incoming value with its entry and latches the result, and in
// the following cycle (busy high) the first matching position is found along
// the cell chain and the cells shift left or right in one step. The result
// appears on o_removed_value and o_status for exactly one cycle, marked by
// o_done, in the cycle in which busy returns low; it cannot be stalled, so the
// receiver must take it then. A new beat may be issued in that same cycle;
// no new beat is taken while busy is high and the cells shift. Inserts into a
// full list are refused with status full; removals from an empty list or of
// a value not present report status miss with a removed value of zero.
module sorted_list_engine (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [2:0]   i_opcode,
    input  wire logic [31:0]  i_value,
    output logic              o_done,
    output logic [31:0]       o_removed_value,
    output logic [1:0]        o_status
);
    import sle_pkg::*;

    logic        w_accept;
    logic        r_busy;
    t_opcode     r_op;
    logic [31:0] r_value;
    logic        r_done;
    logic [31:0] r_removed;
    t_status     r_status;
    t_status     n_status;
    logic [31:0] n_removed;
    logic        w_is_ins;
    logic        w_is_rem;
    logic        w_full;
    logic        w_found;
    t_cell_ctl   w_ctl;

    // Neighbor links: index i+1 is cell i; index 0 and CAPACITY+1 are tie-offs.
    logic [31:0] w_val  [CAPACITY+2];
    logic        w_used [CAPACITY+2];
    logic        w_hit  [CAPACITY+1];
    logic [31:0] w_acc  [CAPACITY+1];

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;

    assign w_is_ins = (r_op == OP_INS_FRONT) || (r_op == OP_INS_ORD) ||
                      (r_op == OP_INS_END);
    assign w_is_rem = (r_op == OP_REM_FRONT) || (r_op == OP_REM_VAL);
    assign w_full   = w_used[CAPACITY];
    assign w_found  = w_hit[CAPACITY];

    // Drive the cells: capture on accept, shift during the busy cycle.
    always_comb begin
        w_ctl.capture = w_accept;
        w_ctl.ins     = r_busy && w_is_ins && !w_full;
        w_ctl.rem     = r_busy && w_is_rem;
        w_ctl.op      = r_op;
    end

    assign w_val[0]           = 32'd0;
    assign w_used[0]          = 1'b0;
    assign w_val[CAPACITY+1]  = 32'd0;
    assign w_used[CAPACITY+1] = 1'b0;
    assign w_hit[0]           = 1'b0;
    assign w_acc[0]           = 32'd0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        sle_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_cmp_value  (i_value),
            .i_new_value  (r_value),
            .i_left_val   (w_val[gi]),
            .i_left_used  (w_used[gi]),
            .i_right_val  (w_val[gi+2]),
            .i_right_used (w_used[gi+2]),
            .i_hit_before (w_hit[gi]),
            .i_acc        (w_acc[gi]),
            .o_val        (w_val[gi+1]),
            .o_used       (w_used[gi+1]),
            .o_hit_thru   (w_hit[gi+1]),
            .o_acc        (w_acc[gi+1])
        );
    end

    // Result of the beat being applied.
    always_comb begin
        n_status  = ST_DONE;
        n_removed = 32'd0;
        if (w_is_ins && w_full) begin
            n_status = ST_FULL;
        end else if (w_is_rem) begin
            if (w_found) begin
                n_removed = w_acc[CAPACITY];
            end else begin
                n_status = ST_MISS;
            end
        end
    end

    // Hold the command for the apply cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_opcode'(i_opcode);
            r_value <= i_value;
        end
        if (r_busy) begin
            r_removed <= n_removed;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= w_accept;
            r_done <= r_busy;
        end
    end

    assign o_done          = r_done;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;

`ifndef NO_ASSERTIONS
    a_busy_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("busy did not follow an accepted beat");

    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_done && !r_busy))
        else $error("result strobe did not follow the apply cycle");

    a_status_legal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_status == ST_DONE || r_status == ST_MISS || r_status == ST_FULL))
        else $error("illegal status code");

    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status != ST_DONE) |-> (r_removed == 32'd0))
        else $error("failed beat returned a nonzero value");
`endif

endmodule

`default_nettype wire
